// File: src/plbcd_pkg.sv
// Shared types and constants for the pinned LRU block cache directory.
package plbcd_pkg;

	localparam int STATUS_W = 4;
	localparam int SLOT_OUT_W = 4;
	localparam int BLOCK_W = 32;
	localparam int OFFSET_OUT_W = 3;
	localparam int PINS_OUT_W = 8;

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT       = 4'd0,
		ST_FILL      = 4'd1,
		ST_EVICT     = 4'd2,
		ST_REL       = 4'd3,
		ST_REL_WB    = 4'd4,
		ST_NOTFOUND  = 4'd5,
		ST_ALLPINNED = 4'd6,
		ST_NOTPINNED = 4'd7,
		ST_OVERFLOW  = 4'd8
	} status_t;

	typedef struct packed {
		logic    load_in;
		logic    lookup;
		logic    scan_step;
		logic    apply;
		status_t status;
	} plbcd_cmd_t;

	typedef struct packed {
		logic op;
		logic dirty;
		logic hit;
		logic pin_full;
		logic pin_zero;
		logic scan_last;
		logic free_found;
		logic victim_found;
		logic out_busy;
	} plbcd_sts_t;

endpackage

// File: src/plbcd_req_if.sv
// Request channel: valid/ready handshake carrying one acquire or release beat.
interface plbcd_req_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [plbcd_pkg::BLOCK_W-1:0] block_index;
	logic                          dirty;

	modport source (output valid, output operation, output block_index, output dirty,
		input ready);
	modport sink (input valid, input operation, input block_index, input dirty,
		output ready);
endinterface

// File: src/plbcd_rsp_if.sv
// Response channel: valid/ready handshake carrying one directory result beat.
interface plbcd_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [plbcd_pkg::STATUS_W-1:0]     status;
	logic [plbcd_pkg::SLOT_OUT_W-1:0]   slot;
	logic                               fill_request;
	logic [plbcd_pkg::BLOCK_W-1:0]      fill_first_block;
	logic                               writeback_request;
	logic [plbcd_pkg::BLOCK_W-1:0]      writeback_block;
	logic [plbcd_pkg::OFFSET_OUT_W-1:0] block_offset;
	logic [plbcd_pkg::PINS_OUT_W-1:0]   pin_count_after;

	modport source (output valid, output status, output slot, output fill_request,
		output fill_first_block, output writeback_request, output writeback_block,
		output block_offset, output pin_count_after, input ready);
	modport sink (input valid, input status, input slot, input fill_request,
		input fill_first_block, input writeback_request, input writeback_block,
		input block_offset, input pin_count_after, output ready);
endinterface

// File: src/plbcd_ctrl.sv
// Controller state machine: sequences lookup, slot scan and state update per beat.
module plbcd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	output logic                  ready,
	input  plbcd_pkg::plbcd_sts_t sts,
	output plbcd_pkg::plbcd_cmd_t cmd
);
	import plbcd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_DECIDE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   acq_miss;

	assign acq_miss = (sts.op == OP_ACQUIRE) && !sts.hit;
	assign ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.status = ST_HIT;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = valid;
			end
			S_LOOK: begin
				cmd.lookup = 1'b1;
			end
			S_DECIDE: begin
				cmd.apply = !acq_miss && !sts.out_busy;
				priority if (sts.op == OP_ACQUIRE) begin
					cmd.status = sts.pin_full ? ST_OVERFLOW : ST_HIT;
				end else if (!sts.hit) begin
					cmd.status = ST_NOTFOUND;
				end else if (sts.pin_zero) begin
					cmd.status = ST_NOTPINNED;
				end else begin
					cmd.status = sts.dirty ? ST_REL_WB : ST_REL;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			S_FINISH: begin
				cmd.apply = !sts.out_busy;
				priority if (sts.free_found) begin
					cmd.status = ST_FILL;
				end else if (sts.victim_found) begin
					cmd.status = ST_EVICT;
				end else begin
					cmd.status = ST_ALLPINNED;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (valid) state_q <= S_LOOK;
				end
				S_LOOK: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (acq_miss) state_q <= S_SCAN;
					else if (!sts.out_busy) state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (sts.scan_last) state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!sts.out_busy) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// File: src/plbcd_dp.sv
// Datapath: directory entries, tag match, slot scan, recency update, result register.
module plbcd_dp #(
	parameter int NUM_LINES = 16,
	parameter int BLOCKS_PER_LINE = 8,
	parameter int INDEX_BITS = 32,
	parameter int PIN_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  plbcd_pkg::plbcd_cmd_t                cmd,
	output plbcd_pkg::plbcd_sts_t                sts,
	input  logic                                 operation,
	input  logic [plbcd_pkg::BLOCK_W-1:0]        block_index,
	input  logic                                 dirty,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [plbcd_pkg::STATUS_W-1:0]       status,
	output logic [plbcd_pkg::SLOT_OUT_W-1:0]     slot,
	output logic                                 fill_request,
	output logic [plbcd_pkg::BLOCK_W-1:0]        fill_first_block,
	output logic                                 writeback_request,
	output logic [plbcd_pkg::BLOCK_W-1:0]        writeback_block,
	output logic [plbcd_pkg::OFFSET_OUT_W-1:0]   block_offset,
	output logic [plbcd_pkg::PINS_OUT_W-1:0]     pin_count_after
);
	import plbcd_pkg::*;

	localparam int IDXW = (INDEX_BITS < BLOCK_W) ? INDEX_BITS : BLOCK_W;
	localparam int OFFB = $clog2(BLOCKS_PER_LINE);
	localparam int TAG_W = (IDXW > OFFB) ? IDXW - OFFB : 1;
	localparam int SLOT_W = $clog2(NUM_LINES);
	localparam logic [IDXW-1:0] OFF_MASK = IDXW'(BLOCKS_PER_LINE - 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_LINES - 1);

	logic [NUM_LINES-1:0] valid_q;
	logic [TAG_W-1:0]     tag_q  [NUM_LINES];
	logic [PIN_BITS-1:0]  pins_q [NUM_LINES];
	logic [SLOT_W-1:0]    rank_q [NUM_LINES];

	logic             op_q;
	logic             dirty_q;
	logic [IDXW-1:0]  idx_q;
	logic [TAG_W-1:0] req_tag;

	logic                hit_q;
	logic [SLOT_W-1:0]   hit_slot_q;
	logic [PIN_BITS-1:0] hit_pins_q;
	logic [SLOT_W-1:0]   hit_rank_q;

	logic                m_hit;
	logic [SLOT_W-1:0]   m_slot;
	logic [PIN_BITS-1:0] m_pins;
	logic [SLOT_W-1:0]   m_rank;

	logic [SLOT_W-1:0] scan_idx_q;
	logic              free_found_q;
	logic [SLOT_W-1:0] free_slot_q;
	logic              victim_found_q;
	logic [SLOT_W-1:0] victim_slot_q;
	logic [SLOT_W-1:0] victim_rank_q;

	logic                s_valid;
	logic [PIN_BITS-1:0] s_pins;
	logic [SLOT_W-1:0]   s_rank;

	logic              do_insert;
	logic              do_promote;
	logic              do_inc;
	logic              do_dec;
	logic              promote_all;
	logic [SLOT_W-1:0] target;
	logic [SLOT_W-1:0] limit;

	logic [SLOT_W-1:0]   r_slot;
	logic                r_fill;
	logic                r_wb;
	logic [PIN_BITS-1:0] r_pins;
	logic [IDXW-1:0]     fill_blk;

	logic                    out_valid_q;
	logic [STATUS_W-1:0]     status_q;
	logic [SLOT_OUT_W-1:0]   slot_q;
	logic                    fill_q;
	logic [BLOCK_W-1:0]      fill_blk_q;
	logic                    wb_q;
	logic [BLOCK_W-1:0]      wb_blk_q;
	logic [OFFSET_OUT_W-1:0] offset_q;
	logic [PINS_OUT_W-1:0]   pins_out_q;

	assign req_tag = TAG_W'(idx_q >> OFFB);
	assign fill_blk = IDXW'(req_tag) << OFFB;

	always_comb begin
		m_hit = 1'b0;
		m_slot = '0;
		m_pins = '0;
		m_rank = '0;
		for (int k = 0; k < NUM_LINES; k++) begin
			if (valid_q[k] && (tag_q[k] == req_tag)) begin
				m_hit = 1'b1;
				m_slot = m_slot | SLOT_W'(k);
				m_pins = m_pins | pins_q[k];
				m_rank = m_rank | rank_q[k];
			end
		end
	end

	assign s_valid = valid_q[scan_idx_q];
	assign s_pins = pins_q[scan_idx_q];
	assign s_rank = rank_q[scan_idx_q];

	always_comb begin
		do_insert = 1'b0;
		do_promote = 1'b0;
		do_inc = 1'b0;
		do_dec = 1'b0;
		promote_all = 1'b0;
		target = hit_slot_q;
		limit = hit_rank_q;
		r_slot = hit_slot_q;
		r_fill = 1'b0;
		r_wb = 1'b0;
		r_pins = hit_pins_q;
		unique case (cmd.status)
			ST_HIT: begin
				do_inc = 1'b1;
				do_promote = 1'b1;
				r_pins = hit_pins_q + PIN_BITS'(1);
			end
			ST_FILL: begin
				do_insert = 1'b1;
				do_promote = 1'b1;
				promote_all = 1'b1;
				target = free_slot_q;
				r_slot = free_slot_q;
				r_fill = 1'b1;
				r_pins = PIN_BITS'(1);
			end
			ST_EVICT: begin
				do_insert = 1'b1;
				do_promote = 1'b1;
				target = victim_slot_q;
				limit = victim_rank_q;
				r_slot = victim_slot_q;
				r_fill = 1'b1;
				r_pins = PIN_BITS'(1);
			end
			ST_REL: begin
				do_dec = 1'b1;
				r_pins = hit_pins_q - PIN_BITS'(1);
			end
			ST_REL_WB: begin
				do_dec = 1'b1;
				r_wb = 1'b1;
				r_pins = hit_pins_q - PIN_BITS'(1);
			end
			ST_NOTFOUND, ST_ALLPINNED: begin
				r_slot = '0;
				r_pins = '0;
			end
			ST_NOTPINNED, ST_OVERFLOW: begin
				r_pins = hit_pins_q;
			end
			default: begin
				r_slot = '0;
				r_pins = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.apply && do_insert) begin
			valid_q[target] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			for (int k = 0; k < NUM_LINES; k++) begin
				if (SLOT_W'(k) == target) begin
					if (do_insert) begin
						tag_q[k] <= req_tag;
						pins_q[k] <= PIN_BITS'(1);
					end else if (do_inc) begin
						pins_q[k] <= pins_q[k] + PIN_BITS'(1);
					end else if (do_dec) begin
						pins_q[k] <= pins_q[k] - PIN_BITS'(1);
					end
					if (do_promote) rank_q[k] <= '0;
				end else if (do_promote && valid_q[k] && (promote_all || rank_q[k] < limit)) begin
					rank_q[k] <= rank_q[k] + SLOT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= operation;
			dirty_q <= dirty;
			idx_q <= block_index[IDXW-1:0];
		end
		if (cmd.lookup) begin
			hit_slot_q <= m_slot;
			hit_pins_q <= m_pins;
			hit_rank_q <= m_rank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			scan_idx_q <= '0;
			free_found_q <= 1'b0;
			victim_found_q <= 1'b0;
		end else if (cmd.lookup) begin
			hit_q <= m_hit;
			scan_idx_q <= '0;
			free_found_q <= 1'b0;
			victim_found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (scan_idx_q != LAST_SLOT) scan_idx_q <= scan_idx_q + SLOT_W'(1);
			if (!s_valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			if ((s_pins == '0) && (!victim_found_q || s_rank > victim_rank_q)) begin
				victim_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			if (!s_valid && !free_found_q) free_slot_q <= scan_idx_q;
			if ((s_pins == '0) && (!victim_found_q || s_rank > victim_rank_q)) begin
				victim_slot_q <= scan_idx_q;
				victim_rank_q <= s_rank;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.apply) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			status_q <= cmd.status;
			slot_q <= SLOT_OUT_W'(r_slot);
			fill_q <= r_fill;
			fill_blk_q <= r_fill ? BLOCK_W'(fill_blk) : '0;
			wb_q <= r_wb;
			wb_blk_q <= r_wb ? BLOCK_W'(idx_q) : '0;
			offset_q <= OFFSET_OUT_W'(idx_q & OFF_MASK);
			pins_out_q <= PINS_OUT_W'(r_pins);
		end
	end

	assign sts.op = op_q;
	assign sts.dirty = dirty_q;
	assign sts.hit = hit_q;
	assign sts.pin_full = &hit_pins_q;
	assign sts.pin_zero = (hit_pins_q == '0);
	assign sts.scan_last = (scan_idx_q == LAST_SLOT);
	assign sts.free_found = free_found_q;
	assign sts.victim_found = victim_found_q;
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign slot = slot_q;
	assign fill_request = fill_q;
	assign fill_first_block = fill_blk_q;
	assign writeback_request = wb_q;
	assign writeback_block = wb_blk_q;
	assign block_offset = offset_q;
	assign pin_count_after = pins_out_q;
endmodule

// File: src/pinned_lru_block_cache_directory.sv
// Top level of the pinned LRU block cache directory.
// Acquire hit and any release: lookup, then decide; the result is registered once the output register is free.
// Acquire miss: lookup, decide, a scan over all NUM_LINES entries, then finish;
// a scan reads one directory entry per cycle to pick the lowest free slot or the victim.
// A new request is taken while the previous result waits in the output register.
// Reset clears all line valid bits and the controller at once; no clearing pass.
module pinned_lru_block_cache_directory #(
	parameter int NUM_LINES = 16,
	parameter int BLOCKS_PER_LINE = 8,
	parameter int INDEX_BITS = 32,
	parameter int PIN_BITS = 8
) (
	input logic        clk,
	input logic        arst_n,
	plbcd_req_if.sink   req,
	plbcd_rsp_if.source rsp
);
	import plbcd_pkg::*;

	plbcd_cmd_t cmd;
	plbcd_sts_t sts;

	plbcd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (req.valid),
		.ready  (req.ready),
		.sts    (sts),
		.cmd    (cmd)
	);

	plbcd_dp #(
		.NUM_LINES       (NUM_LINES),
		.BLOCKS_PER_LINE (BLOCKS_PER_LINE),
		.INDEX_BITS      (INDEX_BITS),
		.PIN_BITS        (PIN_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.operation         (req.operation),
		.block_index       (req.block_index),
		.dirty             (req.dirty),
		.out_valid         (rsp.valid),
		.out_ready         (rsp.ready),
		.status            (rsp.status),
		.slot              (rsp.slot),
		.fill_request      (rsp.fill_request),
		.fill_first_block  (rsp.fill_first_block),
		.writeback_request (rsp.writeback_request),
		.writeback_block   (rsp.writeback_block),
		.block_offset      (rsp.block_offset),
		.pin_count_after   (rsp.pin_count_after)
	);
endmodule
